// ===== rtl/dmbtb_pkg.sv =====
// Shared types and constants for the direct-mapped branch target buffer.
// No dependencies.
`timescale 1ns / 1ps

package dmbtb_pkg;

  localparam int unsigned PC_W       = 32;
  localparam int unsigned TARGET_W   = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned ALIGN_BITS = 2;

  typedef enum logic {
    CmdLookup = 1'b0,
    CmdUpdate = 1'b1
  } cmd_e;

  // resolved request leaving the lookup stage
  typedef struct packed {
    logic strobe;
    logic is_update;
    logic upd_indirect;
    logic hit;
    logic ind_entry;
  } res_t;

endpackage

// ===== rtl/dmbtb_ram.sv =====
// Single-port synchronous RAM holding the buffer entries, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dmbtb_ram #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9,
  parameter int unsigned DATA_W = 55
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dmbtb_stats.sv =====
// Statistics counters and result register.
// Depends on dmbtb_pkg.
`timescale 1ns / 1ps

module dmbtb_stats (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dmbtb_pkg::res_t                res_i,
  input  logic [dmbtb_pkg::TARGET_W-1:0] target_i,
  output logic                           done_o,
  output logic                           hit_o,
  output logic [dmbtb_pkg::TARGET_W-1:0] stored_target_o,
  output logic                           indirect_entry_o,
  output logic [dmbtb_pkg::CNT_W-1:0]    access_count_o,
  output logic [dmbtb_pkg::CNT_W-1:0]    hit_count_o,
  output logic [dmbtb_pkg::CNT_W-1:0]    indirect_update_count_o,
  output logic [dmbtb_pkg::CNT_W-1:0]    indirect_hit_count_o
);

  logic                           done_q;
  logic                           hit_q;
  logic [dmbtb_pkg::TARGET_W-1:0] target_q;
  logic                           ind_entry_q;
  logic [dmbtb_pkg::CNT_W-1:0]    acc_q, acc_d;
  logic [dmbtb_pkg::CNT_W-1:0]    hits_q, hits_d;
  logic [dmbtb_pkg::CNT_W-1:0]    iupd_q, iupd_d;
  logic [dmbtb_pkg::CNT_W-1:0]    ihit_q, ihit_d;
  logic                           lookup;

  assign lookup = res_i.strobe & ~res_i.is_update;

  always_comb begin
    acc_d  = acc_q + dmbtb_pkg::CNT_W'(lookup);
    hits_d = hits_q + dmbtb_pkg::CNT_W'(lookup & res_i.hit);
    ihit_d = ihit_q + dmbtb_pkg::CNT_W'(lookup & res_i.hit & res_i.ind_entry);
    iupd_d = iupd_q
           + dmbtb_pkg::CNT_W'(res_i.strobe & res_i.is_update & res_i.upd_indirect);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      acc_q  <= '0;
      hits_q <= '0;
      iupd_q <= '0;
      ihit_q <= '0;
    end else begin
      done_q <= res_i.strobe;
      acc_q  <= acc_d;
      hits_q <= hits_d;
      iupd_q <= iupd_d;
      ihit_q <= ihit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q       <= res_i.hit;
    target_q    <= target_i;
    ind_entry_q <= res_i.ind_entry;
  end

  assign done_o                  = done_q;
  assign hit_o                   = hit_q;
  assign stored_target_o         = target_q;
  assign indirect_entry_o        = ind_entry_q;
  assign access_count_o          = acc_q;
  assign hit_count_o             = hits_q;
  assign indirect_update_count_o = iupd_q;
  assign indirect_hit_count_o    = ihit_q;

endmodule

// ===== rtl/direct_mapped_branch_target_buffer.sv =====
// Direct-mapped branch target buffer: one request per cycle while not busy;
// the result is registered after the entry RAM read, then the tag compare and
// counter update. Updates write the entry RAM in the accept cycle; a lookup in
// the next cycle sees the new entry. The receiver cannot stall. After reset,
// busy_o stays high while the RAM is cleared one entry per cycle; it drops
// after the last entry. Depends on dmbtb_pkg, dmbtb_ram, dmbtb_stats.
`timescale 1ns / 1ps

module direct_mapped_branch_target_buffer #(
  parameter int unsigned ENTRY_COUNT = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           cmd_i,
  input  logic [dmbtb_pkg::PC_W-1:0]     pc_i,
  input  logic [dmbtb_pkg::TARGET_W-1:0] new_target_i,
  input  logic                           indirect_flag_i,
  output logic                           done_o,
  output logic                           hit_o,
  output logic [dmbtb_pkg::TARGET_W-1:0] stored_target_o,
  output logic                           indirect_entry_o,
  output logic [dmbtb_pkg::CNT_W-1:0]    access_count_o,
  output logic [dmbtb_pkg::CNT_W-1:0]    hit_count_o,
  output logic [dmbtb_pkg::CNT_W-1:0]    indirect_update_count_o,
  output logic [dmbtb_pkg::CNT_W-1:0]    indirect_hit_count_o
);

  localparam int unsigned IDX_W  = $clog2(ENTRY_COUNT);
  localparam int unsigned LOG2N  = $clog2(ENTRY_COUNT + 1) - 1;
  localparam int unsigned TAG_LO = dmbtb_pkg::ALIGN_BITS + LOG2N;
  localparam int unsigned TAG_W  = dmbtb_pkg::PC_W - TAG_LO;
  localparam int unsigned ENT_W  = 2 + TAG_W + dmbtb_pkg::TARGET_W;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ENTRY_COUNT - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

  typedef enum logic {
    StInit,
    StRun
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_idx_q, clr_idx_d;
  logic              busy_q, busy_d;

  logic              accept;
  logic [IDX_W-1:0]  req_idx;
  logic [TAG_W-1:0]  req_tag;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_addr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  logic              s1_vld_q;
  dmbtb_pkg::cmd_e   s1_cmd_q;
  logic [TAG_W-1:0]  s1_tag_q;
  logic              s1_ind_q;

  logic              rd_valid, rd_ind;
  logic [TAG_W-1:0]  rd_tag;
  logic [dmbtb_pkg::TARGET_W-1:0] rd_target;
  logic              s1_lookup;
  dmbtb_pkg::res_t   res;
  logic [dmbtb_pkg::TARGET_W-1:0] res_target;

  assign accept  = start_i & ~busy_q;
  assign req_idx = pc_i[dmbtb_pkg::ALIGN_BITS +: IDX_W] & IDX_MASK;
  assign req_tag = pc_i[dmbtb_pkg::PC_W-1:TAG_LO];

  // reset clearing sweep
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    busy_d    = busy_q;
    unique case (state_q)
      StInit: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == LAST_IDX) begin
          state_d = StRun;
          busy_d  = 1'b0;
        end
      end
      StRun: begin
        busy_d = 1'b0;
      end
      default: begin
        state_d = StInit;
        busy_d  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StInit;
      clr_idx_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      busy_q    <= busy_d;
    end
  end

  assign busy_o = busy_q;

  // entry layout: {valid, indirect, tag, target}
  always_comb begin
    if (state_q == StInit) begin
      ram_we    = 1'b1;
      ram_re    = 1'b0;
      ram_addr  = clr_idx_q;
      ram_wdata = '0;
    end else begin
      ram_we    = accept & (cmd_i == dmbtb_pkg::CmdUpdate);
      ram_re    = accept & (cmd_i == dmbtb_pkg::CmdLookup);
      ram_addr  = req_idx;
      ram_wdata = {1'b1, indirect_flag_i, req_tag, new_target_i};
    end
  end

  dmbtb_ram #(
    .DEPTH  (ENTRY_COUNT),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= dmbtb_pkg::cmd_e'(cmd_i);
      s1_tag_q <= req_tag;
      s1_ind_q <= indirect_flag_i;
    end
  end

  assign {rd_valid, rd_ind, rd_tag, rd_target} = ram_rdata;
  assign s1_lookup = s1_vld_q & (s1_cmd_q == dmbtb_pkg::CmdLookup);

  always_comb begin
    res.strobe       = s1_vld_q;
    res.is_update    = s1_cmd_q == dmbtb_pkg::CmdUpdate;
    res.upd_indirect = s1_ind_q;
    res.hit          = s1_lookup & rd_valid & (rd_tag == s1_tag_q);
    res.ind_entry    = s1_lookup & rd_valid & rd_ind;
    res_target       = s1_lookup ? rd_target : '0;
  end

  dmbtb_stats u_stats (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .res_i                   (res),
    .target_i                (res_target),
    .done_o                  (done_o),
    .hit_o                   (hit_o),
    .stored_target_o         (stored_target_o),
    .indirect_entry_o        (indirect_entry_o),
    .access_count_o          (access_count_o),
    .hit_count_o             (hit_count_o),
    .indirect_update_count_o (indirect_update_count_o),
    .indirect_hit_count_o    (indirect_hit_count_o)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for direct_mapped_branch_target_buffer: a shadow BTB
// predicts each result, and a monitor checks every done_o strobe against it.
// Depends on dmbtb_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

typedef struct packed {
  logic        hit;
  logic [31:0] stored_target;
  logic        indirect_entry;
  logic [31:0] access_count;
  logic [31:0] hit_count;
  logic [31:0] indirect_update_count;
  logic [31:0] indirect_hit_count;
} btb_result_t;

class btb_shadow;
  localparam int unsigned SLOTS = 512;
  localparam int unsigned IDX_W = $clog2(SLOTS);

  bit          slot_valid[SLOTS];
  bit [31:0]   slot_tag[SLOTS];
  bit [31:0]   slot_target[SLOTS];
  bit          slot_indirect[SLOTS];
  bit [31:0]   lookups;
  bit [31:0]   hits;
  bit [31:0]   ind_updates;
  bit [31:0]   ind_hits;
  btb_result_t pending_results[$];
  int unsigned errors;

  function void note_request(dmbtb_pkg::cmd_e cmd, bit [31:0] pc, bit [31:0] tgt,
                             bit ind);
    int unsigned slot;
    bit [31:0]   tag;
    btb_result_t r;
    slot = (pc >> dmbtb_pkg::ALIGN_BITS) & (SLOTS - 1);
    tag  = pc >> (dmbtb_pkg::ALIGN_BITS + IDX_W);
    r    = '0;
    if (cmd == dmbtb_pkg::CmdLookup) begin
      lookups++;
      r.hit = slot_valid[slot] && (slot_tag[slot] == tag);
      if (r.hit) begin
        hits++;
        if (slot_indirect[slot]) ind_hits++;
      end
      r.stored_target  = slot_target[slot];
      r.indirect_entry = slot_valid[slot] && slot_indirect[slot];
    end else begin
      if (ind) ind_updates++;
      slot_valid[slot]    = 1'b1;
      slot_tag[slot]      = tag;
      slot_target[slot]   = tgt;
      slot_indirect[slot] = ind;
    end
    r.access_count          = lookups;
    r.hit_count             = hits;
    r.indirect_update_count = ind_updates;
    r.indirect_hit_count    = ind_hits;
    pending_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_result(logic hit, logic [31:0] tgt, logic ind_entry,
                             logic [31:0] acc, logic [31:0] hcnt,
                             logic [31:0] iupd, logic [31:0] ihit);
    btb_result_t e;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: result with no request outstanding", $time);
      return;
    end
    e = pending_results.pop_front();
    compare_field("hit", {31'b0, e.hit}, {31'b0, hit});
    compare_field("stored_target", e.stored_target, tgt);
    compare_field("indirect_entry", {31'b0, e.indirect_entry}, {31'b0, ind_entry});
    compare_field("access_count", e.access_count, acc);
    compare_field("hit_count", e.hit_count, hcnt);
    compare_field("indirect_update_count", e.indirect_update_count, iupd);
    compare_field("indirect_hit_count", e.indirect_hit_count, ihit);
  endfunction
endclass

module tb;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned HOT_N = 24;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        cmd_i;
  logic [31:0] pc_i;
  logic [31:0] new_target_i;
  logic        indirect_flag_i;
  logic        done_o;
  logic        hit_o;
  logic [31:0] stored_target_o;
  logic        indirect_entry_o;
  logic [31:0] access_count_o;
  logic [31:0] hit_count_o;
  logic [31:0] indirect_update_count_o;
  logic [31:0] indirect_hit_count_o;

  btb_shadow   sb = new();
  int unsigned idle_cycles = 0;
  bit [31:0]   hot_pcs[HOT_N];

  direct_mapped_branch_target_buffer #(.ENTRY_COUNT(512)) uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .start_i                (start_i),
    .busy_o                 (busy_o),
    .cmd_i                  (cmd_i),
    .pc_i                   (pc_i),
    .new_target_i           (new_target_i),
    .indirect_flag_i        (indirect_flag_i),
    .done_o                 (done_o),
    .hit_o                  (hit_o),
    .stored_target_o        (stored_target_o),
    .indirect_entry_o       (indirect_entry_o),
    .access_count_o         (access_count_o),
    .hit_count_o            (hit_count_o),
    .indirect_update_count_o(indirect_update_count_o),
    .indirect_hit_count_o   (indirect_hit_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      sb.check_result(hit_o, stored_target_o, indirect_entry_o, access_count_o,
                      hit_count_o, indirect_update_count_o, indirect_hit_count_o);
    end
  end

  // no request accepted and no result for too long
  always @(posedge clk_i) begin
    if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap(int unsigned n);
    int unsigned r;
    if ((n / 150) % 3 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_request(dmbtb_pkg::cmd_e cmd, logic [31:0] pc, logic [31:0] tgt,
                              logic ind, int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    cmd_i           <= cmd;
    pc_i            <= pc;
    new_target_i    <= tgt;
    indirect_flag_i <= ind;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_request(cmd, pc, tgt, ind);
  endtask

  initial begin
    dmbtb_pkg::cmd_e cmd;
    bit [31:0]       pc;
    int unsigned     r;
    rst_ni          <= 1'b0;
    start_i         <= 1'b0;
    cmd_i           <= dmbtb_pkg::CmdLookup;
    pc_i            <= '0;
    new_target_i    <= '0;
    indirect_flag_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, aliasing, low pc bits, back-to-back
    send_request(dmbtb_pkg::CmdLookup, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 0);
    send_request(dmbtb_pkg::CmdUpdate, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'h0000_0000, 32'h0000_0000, 1'b0, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'h0000_0003, 32'h0000_0000, 1'b0, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'h0000_0800, 32'h0000_0000, 1'b0, 0);
    send_request(dmbtb_pkg::CmdUpdate, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
    send_request(dmbtb_pkg::CmdUpdate, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'h7FFF_FFFC, 32'h0000_0000, 1'b0, 2);
    send_request(dmbtb_pkg::CmdUpdate, 32'h0000_0000, 32'h5A5A_5A5A, 1'b0, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'h0000_0000, 32'h0000_0000, 1'b1, 0);
    send_request(dmbtb_pkg::CmdUpdate, 32'h0000_0800, 32'h1234_5678, 1'b1, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'h0000_0000, 32'h0000_0000, 1'b0, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'h0000_0801, 32'h0000_0000, 1'b0, 0);
    send_request(dmbtb_pkg::CmdUpdate, 32'h8000_07FC, 32'h8000_0001, 1'b0, 1);
    send_request(dmbtb_pkg::CmdLookup, 32'h8000_07FE, 32'h0000_0000, 1'b0, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'h0000_07FC, 32'h0000_0000, 1'b0, 0);
    send_request(dmbtb_pkg::CmdUpdate, 32'h8000_07FC, 32'h0000_0002, 1'b1, 0);
    send_request(dmbtb_pkg::CmdLookup, 32'h8000_07FC, 32'h0000_0000, 1'b0, 0);

    for (int i = 0; i < HOT_N / 2; i++) hot_pcs[i] = $urandom();
    for (int i = HOT_N / 2; i < HOT_N; i++)
      hot_pcs[i] = (hot_pcs[i - HOT_N / 2] & 32'h0000_07FF) | ($urandom() & 32'hFFFF_F800);

    // random: mostly a small hot set so lookups hit, plus scattered addresses
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 199) hot_pcs[$urandom_range(0, HOT_N - 1)] = $urandom();
      r = $urandom_range(0, 99);
      if (r < 85) pc = hot_pcs[$urandom_range(0, HOT_N - 1)] ^ 32'($urandom_range(0, 3));
      else pc = $urandom();
      cmd = ($urandom_range(0, 99) < 35) ? dmbtb_pkg::CmdUpdate : dmbtb_pkg::CmdLookup;
      send_request(cmd, pc, $urandom(), 1'($urandom_range(0, 1)), pick_gap(n));
    end
    start_i <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/dmbtb_pkg.sv
rtl/dmbtb_ram.sv
rtl/dmbtb_stats.sv
rtl/direct_mapped_branch_target_buffer.sv
dv/tb.sv
